>>> src/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the selective color desaturation block:
// pixel and result words, register indexes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package scd_pkg;

  // channel and register widths
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // threshold after reset, about 0.1 in Q1.15
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd3277;

  // register stages inside the chroma test
  localparam int unsigned CHK_LAT = 7;

  // floor(s/3) as (s * ceil(2^20/3)) >> 20, exact for s < 2^19
  localparam int unsigned      GRAY_SHIFT = 20;
  localparam logic [18:0]      GRAY_RECIP = 19'd349526;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_BASE_RED   = 2'd1,
    CFG_BASE_GREEN = 2'd2,
    CFG_BASE_BLUE  = 2'd3
  } cfg_idx_e;

  // input word
  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } pixel_t;

  // result word
  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              kept_color;
  } result_t;

  // reference color
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } base_t;

endpackage

>>> src/scd_chroma_test.sv
// ----------------------------------------------------------------------------
// scd_chroma_test
// Pipelined exact chroma test: keep when 4*dot^2*2^60 > (2^31-T^2)^2*|p|^2*|b|^2,
// with zero-length and large-threshold cases. Seven register stages.
// ----------------------------------------------------------------------------
module scd_chroma_test (
  input  logic                        clk_i,
  input  scd_pkg::pixel_t             pixel_i,
  input  scd_pkg::base_t              base_i,
  input  logic [scd_pkg::CHAN_W-1:0]  threshold_i,
  output logic                        keep_o
);
  import scd_pkg::*;

  typedef struct packed {
    logic zero;
    logic big;
  } chk_flags_t;

  logic [2:0][CHAN_W-1:0] pch;
  logic [2:0][CHAN_W-1:0] bch;

  // stage 1: channel products
  logic [2:0][31:0] s1_psq_q, s1_dot_q, s1_bsq_q;
  logic [31:0]      s1_tsq_q;
  logic             s1_zero_q;
  // stage 2: lengths and dot product
  logic [33:0]      s2_plen_q, s2_blen_q, s2_dot_q;
  logic [31:0]      s2_dd_q;
  chk_flags_t       s2_flags_q;
  // stage 3: partial products of 17 bit and 16 bit halves
  logic [33:0]      s3_dhh_q, s3_dhl_q, s3_dll_q;
  logic [33:0]      s3_phh_q, s3_phl_q, s3_plh_q, s3_pll_q;
  logic [31:0]      s3_thh_q, s3_thl_q, s3_tll_q;
  chk_flags_t       s3_flags_q;
  // stage 4: dot^2, |p|^2*|b|^2, (2^31-T^2)^2
  logic [67:0]      s4_dsq_q, s4_pb_q;
  logic [63:0]      s4_tt_q;
  chk_flags_t       s4_flags_q;
  // stage 5: 32 bit partial products of the right side
  logic [63:0]      s5_m00_q, s5_m01_q, s5_m10_q, s5_m11_q;
  logic [35:0]      s5_m02_q, s5_m12_q;
  logic [67:0]      s5_dsq_q;
  chk_flags_t       s5_flags_q;
  // stage 6: sums at equal weight
  logic [63:0]      s6_w0_q;
  logic [64:0]      s6_w32_q, s6_w64_q;
  logic [35:0]      s6_w96_q;
  logic [67:0]      s6_dsq_q;
  chk_flags_t       s6_flags_q;
  // stage 7: both sides of the compare
  logic [129:0]     s7_lhs_q;
  logic [131:0]     s7_rhs_q;
  chk_flags_t       s7_flags_q;

  assign pch[0] = pixel_i.in_red;
  assign pch[1] = pixel_i.in_green;
  assign pch[2] = pixel_i.in_blue;
  assign bch[0] = base_i.red;
  assign bch[1] = base_i.green;
  assign bch[2] = base_i.blue;

  // stage 1
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_psq_q[i] <= 32'(pch[i]) * 32'(pch[i]);
      s1_dot_q[i] <= 32'(pch[i]) * 32'(bch[i]);
      s1_bsq_q[i] <= 32'(bch[i]) * 32'(bch[i]);
    end
    s1_tsq_q  <= 32'(threshold_i) * 32'(threshold_i);
    s1_zero_q <= (pch == '0) || (bch == '0);
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    s2_plen_q        <= 34'(s1_psq_q[0]) + 34'(s1_psq_q[1]) + 34'(s1_psq_q[2]);
    s2_blen_q        <= 34'(s1_bsq_q[0]) + 34'(s1_bsq_q[1]) + 34'(s1_bsq_q[2]);
    s2_dot_q         <= 34'(s1_dot_q[0]) + 34'(s1_dot_q[1]) + 34'(s1_dot_q[2]);
    s2_dd_q          <= 32'h8000_0000 - s1_tsq_q;
    s2_flags_q.zero  <= s1_zero_q;
    // t^2 >= 2 keeps every nonzero pixel when the reference is nonzero
    s2_flags_q.big   <= s1_tsq_q[31];
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    s3_dhh_q   <= 34'(s2_dot_q[33:17]) * 34'(s2_dot_q[33:17]);
    s3_dhl_q   <= 34'(s2_dot_q[33:17]) * 34'(s2_dot_q[16:0]);
    s3_dll_q   <= 34'(s2_dot_q[16:0])  * 34'(s2_dot_q[16:0]);
    s3_phh_q   <= 34'(s2_plen_q[33:17]) * 34'(s2_blen_q[33:17]);
    s3_phl_q   <= 34'(s2_plen_q[33:17]) * 34'(s2_blen_q[16:0]);
    s3_plh_q   <= 34'(s2_plen_q[16:0])  * 34'(s2_blen_q[33:17]);
    s3_pll_q   <= 34'(s2_plen_q[16:0])  * 34'(s2_blen_q[16:0]);
    s3_thh_q   <= 32'(s2_dd_q[31:16]) * 32'(s2_dd_q[31:16]);
    s3_thl_q   <= 32'(s2_dd_q[31:16]) * 32'(s2_dd_q[15:0]);
    s3_tll_q   <= 32'(s2_dd_q[15:0])  * 32'(s2_dd_q[15:0]);
    s3_flags_q <= s2_flags_q;
  end

  // stage 4: cross terms appear twice in a square, hence one extra bit of shift
  always_ff @(posedge clk_i) begin
    s4_dsq_q   <= (68'(s3_dhh_q) << 34) + (68'(s3_dhl_q) << 18) + 68'(s3_dll_q);
    s4_pb_q    <= (68'(s3_phh_q) << 34) + (68'(s3_phl_q) << 17)
                + (68'(s3_plh_q) << 17) + 68'(s3_pll_q);
    s4_tt_q    <= (64'(s3_thh_q) << 32) + (64'(s3_thl_q) << 17) + 64'(s3_tll_q);
    s4_flags_q <= s3_flags_q;
  end

  // stage 5
  always_ff @(posedge clk_i) begin
    s5_m00_q   <= 64'(s4_tt_q[31:0])  * 64'(s4_pb_q[31:0]);
    s5_m01_q   <= 64'(s4_tt_q[31:0])  * 64'(s4_pb_q[63:32]);
    s5_m10_q   <= 64'(s4_tt_q[63:32]) * 64'(s4_pb_q[31:0]);
    s5_m11_q   <= 64'(s4_tt_q[63:32]) * 64'(s4_pb_q[63:32]);
    s5_m02_q   <= 36'(s4_tt_q[31:0])  * 36'(s4_pb_q[67:64]);
    s5_m12_q   <= 36'(s4_tt_q[63:32]) * 36'(s4_pb_q[67:64]);
    s5_dsq_q   <= s4_dsq_q;
    s5_flags_q <= s4_flags_q;
  end

  // stage 6
  always_ff @(posedge clk_i) begin
    s6_w0_q    <= s5_m00_q;
    s6_w32_q   <= 65'(s5_m01_q) + 65'(s5_m10_q);
    s6_w64_q   <= 65'(s5_m11_q) + 65'(s5_m02_q);
    s6_w96_q   <= s5_m12_q;
    s6_dsq_q   <= s5_dsq_q;
    s6_flags_q <= s5_flags_q;
  end

  // stage 7
  always_ff @(posedge clk_i) begin
    s7_rhs_q   <= 132'(s6_w0_q) + (132'(s6_w32_q) << 32)
                + (132'(s6_w64_q) << 64) + (132'(s6_w96_q) << 96);
    s7_lhs_q   <= {s6_dsq_q, 62'd0};
    s7_flags_q <= s6_flags_q;
  end

  // final compare
  assign keep_o = !s7_flags_q.zero && (s7_flags_q.big || (132'(s7_lhs_q) > s7_rhs_q));

endmodule

>>> src/selective_color_desaturate.sv
// ----------------------------------------------------------------------------
// selective_color_desaturate
// Keeps pixels whose chromaticity lies near a reference color, grays the rest.
// ----------------------------------------------------------------------------
// One pixel word is taken in every cycle in which start is high and busy is low;
// busy is high only in the first cycle after reset. Each result word appears on
// result_o with valid_o high for one cycle, after its pixel has passed the seven
// stages of the wide product chain in the chroma test and the output register.
// The receiver cannot stall, and the block never needs to. Register writes go
// through cfg_we_i, cfg_idx_i and cfg_data_i and must be made while no pixel is
// in flight. Channels and reference components use the low CHANNEL_BITS bits.
module selective_color_desaturate #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  scd_pkg::pixel_t                   pixel_i,
  input  logic                              cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              valid_o,
  output scd_pkg::result_t                  result_o
);
  import scd_pkg::*;

  localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((32'd1 << CHANNEL_BITS) - 32'd1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] gray;
  } hold_t;

  logic                  busy_q;
  logic                  accept;
  logic [CHAN_W-1:0]     threshold_q;
  base_t                 base_q;
  base_t                 base_m;
  pixel_t                pix_m;
  logic                  keep;

  pixel_t                s1_pix_q;
  logic [17:0]           s1_sum_q;
  logic [36:0]           gray_prod;
  hold_t                 hold_q [CHK_LAT-1];
  logic [CHK_LAT-1:0]    vld_q;
  logic                  valid_q;
  result_t               result_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // busy only in the cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      base_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
        CFG_BASE_RED:   base_q.red   <= cfg_data_i;
        CFG_BASE_GREEN: base_q.green <= cfg_data_i;
        CFG_BASE_BLUE:  base_q.blue  <= cfg_data_i;
      endcase
    end
  end

  // channel width masking
  assign pix_m.in_red   = pixel_i.in_red   & CHAN_MASK;
  assign pix_m.in_green = pixel_i.in_green & CHAN_MASK;
  assign pix_m.in_blue  = pixel_i.in_blue  & CHAN_MASK;
  assign base_m.red     = base_q.red       & CHAN_MASK;
  assign base_m.green   = base_q.green     & CHAN_MASK;
  assign base_m.blue    = base_q.blue      & CHAN_MASK;

  scd_chroma_test u_chroma (
    .clk_i       (clk_i),
    .pixel_i     (pix_m),
    .base_i      (base_m),
    .threshold_i (threshold_q),
    .keep_o      (keep)
  );

  // valid line alongside the chroma pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[CHK_LAT-2:0], accept};
      valid_q <= vld_q[CHK_LAT-1];
    end
  end

  // gray path: channel sum, then divide by three
  assign gray_prod = 37'(s1_sum_q) * 37'(GRAY_RECIP);

  always_ff @(posedge clk_i) begin
    s1_pix_q <= pix_m;
    s1_sum_q <= 18'(pix_m.in_red) + 18'(pix_m.in_green) + 18'(pix_m.in_blue);
    hold_q[0] <= '{red:   s1_pix_q.in_red,
                   green: s1_pix_q.in_green,
                   blue:  s1_pix_q.in_blue,
                   gray:  gray_prod[GRAY_SHIFT +: CHAN_W]};
    for (int i = 1; i < CHK_LAT - 1; i++) begin
      hold_q[i] <= hold_q[i-1];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (vld_q[CHK_LAT-1]) begin
      if (keep) begin
        result_q <= '{out_red:    hold_q[CHK_LAT-2].red,
                      out_green:  hold_q[CHK_LAT-2].green,
                      out_blue:   hold_q[CHK_LAT-2].blue,
                      kept_color: 1'b1};
      end else begin
        result_q <= '{out_red:    hold_q[CHK_LAT-2].gray,
                      out_green:  hold_q[CHK_LAT-2].gray,
                      out_blue:   hold_q[CHK_LAT-2].gray,
                      kept_color: 1'b0};
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // a result word always follows an accepted pixel by the full latency
  a_result_follows_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, CHK_LAT + 1))
    else $error("result word without matching pixel");

  // grayed words carry one value on all channels
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !result_o.kept_color) |->
      (result_o.out_red == result_o.out_green && result_o.out_green == result_o.out_blue))
    else $error("gray channels differ");

  // kept words pass the masked pixel unchanged
  a_kept_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.kept_color) |->
      (result_o.out_red   == $past(pixel_i.in_red   & CHAN_MASK, CHK_LAT + 1) &&
       result_o.out_green == $past(pixel_i.in_green & CHAN_MASK, CHK_LAT + 1) &&
       result_o.out_blue  == $past(pixel_i.in_blue  & CHAN_MASK, CHK_LAT + 1)))
    else $error("kept pixel altered");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for selective_color_desaturate. Pixel words are sent
// through the start/busy handshake with random idle gaps. A scoreboard
// predicts each result word with exact wide-integer chroma arithmetic and
// compares it field by field. The run covers directed corner pixels, then
// random phases under many threshold and reference color settings.
// ----------------------------------------------------------------------------
module tb;
  import scd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = CHK_LAT + 4;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_PIXELS = 120;

  // predicts result words and checks them in order
  class splash_scoreboard;
    logic [CFG_DATA_W-1:0] thresh;
    base_t                 ref_color;
    result_t               expected_q[$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           kept;
    int unsigned           grayed;

    function new();
      thresh    = THRESHOLD_RESET;
      ref_color = '0;
      errors    = 0;
      checked   = 0;
      kept      = 0;
      grayed    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_THRESHOLD:  thresh          = val;
        CFG_BASE_RED:   ref_color.red   = val;
        CFG_BASE_GREEN: ref_color.green = val;
        CFG_BASE_BLUE:  ref_color.blue  = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // keep test: 4*dot^2 * 2^60 > (2^31 - T^2)^2 * |p|^2 * |b|^2
    function result_t predict_pixel(pixel_t p);
      logic [191:0] r, g, b, br, bg, bb;
      logic [191:0] plen, blen, dot, tsq, margin, lhs, rhs;
      logic [17:0]  sum;
      logic [15:0]  gray;
      result_t      res;
      r      = 192'(p.in_red);
      g      = 192'(p.in_green);
      b      = 192'(p.in_blue);
      br     = 192'(ref_color.red);
      bg     = 192'(ref_color.green);
      bb     = 192'(ref_color.blue);
      plen   = r * r + g * g + b * b;
      blen   = br * br + bg * bg + bb * bb;
      dot    = r * br + g * bg + b * bb;
      tsq    = 192'(thresh) * 192'(thresh);
      lhs    = (dot * dot) << 62;
      margin = (192'd1 << 31) - tsq;
      rhs    = margin * margin * plen * blen;
      sum    = 18'(p.in_red) + 18'(p.in_green) + 18'(p.in_blue);
      gray   = 16'(sum / 18'd3);
      if (plen != 0 && blen != 0 && (tsq >= (192'd1 << 31) || lhs > rhs)) begin
        res = {p.in_red, p.in_green, p.in_blue, 1'b1};
      end else begin
        res = {gray, gray, gray, 1'b0};
      end
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      expected_q.push_back(predict_pixel(p));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with no pixel pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.kept_color) kept++;
      else grayed++;
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
      compare_field("kept_color", 16'(want.kept_color), 16'(got.kept_color));
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  pixel_t                pixel_i    = '0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  valid_o;
  result_t               result_o;

  splash_scoreboard      sb = new();
  int unsigned           stall_cycles = 0;
  int unsigned           settings_used = 0;

  always #10 clk_i = ~clk_i;

  selective_color_desaturate i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

  // monitor: accepted words, register writes and the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (start && !busy) sb.note_pixel(pixel_i);
      if (valid_o) sb.check_result(result_o);
      if ((start && !busy) || valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
        $display("selective_color_desaturate verification failed");
        $finish;
      end
    end
  end

  // one pixel word, after an optional idle gap
  task automatic send_pixel(pixel_t p, int unsigned idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and let every pending result word come out
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all four registers back to back while idle
  task automatic write_regs(logic [CFG_DATA_W-1:0] thr, base_t c);
    cfg_idx_e              order[4];
    logic [CFG_DATA_W-1:0] vals[4];
    order = '{CFG_THRESHOLD, CFG_BASE_RED, CFG_BASE_GREEN, CFG_BASE_BLUE};
    vals  = '{thr, c.red, c.green, c.blue};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic base_t random_color();
    logic [15:0] ch[3];
    for (int k = 0; k < 3; k++)
      ch[k] = ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
    return {ch[0], ch[1], ch[2]};
  endfunction

  // half the pixels near the reference direction, the rest random, tiny, saturated or gray
  function automatic pixel_t make_pixel(base_t c);
    logic [15:0] ch[3];
    logic [15:0] bc[3];
    int          num;
    int          sh;
    int          jitter;
    int          v;
    logic [15:0] level;
    bc = '{c.red, c.green, c.blue};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        num = $urandom_range(1, 512);
        sh  = $urandom_range(0, 11);
        for (int k = 0; k < 3; k++) begin
          v      = (int'(bc[k]) * num) >>> 8;
          jitter = $urandom_range(0, (1 << sh) - 1);
          if ($urandom_range(0, 1)) v = v - jitter;
          else v = v + jitter;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          ch[k] = v[15:0];
        end
      end
      5, 6: begin
        for (int k = 0; k < 3; k++) ch[k] = 16'($urandom_range(0, 65535));
      end
      7: begin
        for (int k = 0; k < 3; k++) ch[k] = 16'($urandom_range(0, 3));
      end
      8: begin
        for (int k = 0; k < 3; k++) ch[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        level = 16'($urandom_range(0, 65535));
        for (int k = 0; k < 3; k++) ch[k] = level;
      end
    endcase
    return {ch[0], ch[1], ch[2]};
  endfunction

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] thr;
    base_t                 c;
    bit                    dense;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero-length reference grays everything
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF}, $urandom_range(0, 3));
    send_pixel({16'h0000, 16'h0000, 16'h0000}, $urandom_range(0, 3));

    // pure red reference, default threshold
    write_regs(THRESHOLD_RESET, {16'hFFFF, 16'h0000, 16'h0000});
    send_pixel({16'hFFFF, 16'h0000, 16'h0000}, 0);
    send_pixel({16'h0001, 16'h0000, 16'h0000}, 0);
    send_pixel({16'h0000, 16'h0000, 16'h0000}, $urandom_range(0, 3));
    send_pixel({16'h0000, 16'hFFFF, 16'h0000}, 0);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF}, $urandom_range(0, 3));
    send_pixel({16'hFFFF, 16'd3000, 16'h0000}, 0);
    send_pixel({16'hFFFF, 16'd9000, 16'h0000}, 0);
    send_pixel({16'h0002, 16'h0001, 16'h0000}, $urandom_range(0, 3));
    send_pixel({16'hFFFE, 16'hFFFF, 16'hFFFD}, 0);

    // zero threshold: even an exact direction match is grayed
    write_regs(16'h0000, {16'd100, 16'd200, 16'd300});
    send_pixel({16'd100, 16'd200, 16'd300}, 0);
    send_pixel({16'd200, 16'd400, 16'd600}, 0);
    send_pixel({16'd101, 16'd200, 16'd300}, $urandom_range(0, 3));

    // largest threshold keeps every nonzero pixel
    write_regs(16'hFFFF, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'hFFFF, 16'h0000, 16'h0000}, 0);
    send_pixel({16'h0000, 16'h0000, 16'h0001}, 0);
    send_pixel({16'h0000, 16'h0000, 16'h0000}, 0);

    // threshold just under t^2 = 2, orthogonal pixel still grayed
    write_regs(16'd46340, {16'h0000, 16'h0000, 16'hFFFF});
    send_pixel({16'hFFFF, 16'h0000, 16'h0000}, 0);
    send_pixel({16'h0001, 16'h0001, 16'h0001}, $urandom_range(0, 3));
    send_pixel({16'hFFFF, 16'hFFFF, 16'h0000}, 0);

    // threshold just over t^2 = 2
    write_regs(16'd46341, {16'h0000, 16'h0000, 16'hFFFF});
    send_pixel({16'hFFFF, 16'h0000, 16'h0000}, 0);
    send_pixel({16'h0000, 16'h0000, 16'h0000}, 0);

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      c = random_color();
      case (ph)
        0: thr = 16'h0000;
        1: thr = 16'hFFFF;
        2: thr = 16'd46340;
        3: thr = 16'd46341;
        4: begin
          thr = THRESHOLD_RESET;
          c   = {16'hFFFF, 16'hFFFF, 16'hFFFF};
        end
        5: begin
          thr = 16'($urandom_range(0, 4000));
          c   = {16'h0001, 16'h0000, 16'h0000};
        end
        6: begin
          thr = 16'($urandom_range(0, 65535));
          c   = '0;
        end
        default: thr = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 6000));
      endcase
      write_regs(thr, c);
      dense = ($urandom_range(0, 2) == 0);
      repeat (PHASE_PIXELS) send_pixel(make_pixel(c), dense ? 0 : $urandom_range(0, 14));
    end

    settle();
    $display("checked %0d result words under %0d register settings", sb.checked,
             settings_used);
    $display("%0d pixels kept their color, %0d were grayed", sb.kept, sb.grayed);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("selective_color_desaturate verification clean");
    end else begin
      $display("selective_color_desaturate verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/scd_pkg.sv
src/scd_chroma_test.sv
src/selective_color_desaturate.sv
tb/sv/tb.sv
